### src/svn_pkg.sv
// shared types and constants for the smooth vertex normal block
// no dependencies
package svn_pkg;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // width of cross product terms and normaliser inputs
  localparam int CW = 36;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TRI,
    OP_READ,
    OP_READ_BAD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [9:0]         idx;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [9:0]         ca;
    logic [9:0]         cb;
    logic [9:0]         cc;
    logic               b_new;
    logic               c_new;
  } cmd_t;

endpackage

### src/smooth_vertex_normals.sv
// top level of the smooth vertex normal block
// depends on svn_pkg, svn_front and svn_back
//
// channel   direction  transfer when     fields
// command   in         start && !busy   kind, vertex_index, pos_x/y/z, corner_a/b/c
// result    out        done (one cycle)  read_index, normal_x/y/z, zero_length
//
// a command sits in a two-entry queue; busy is high while the queue is full
// load: write position, clear sum; out-of-range read: zeros; read: sum read + normaliser
// normaliser: up to 29 scaling shifts, 3 squares, 31 root steps, 3 bit-serial divides
// triangle: position reads, cross product, normaliser, sum update per distinct corner
// rst clears control state only; the memories hold nothing until written
// results cannot be held off: done strobes for exactly one cycle
module smooth_vertex_normals #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [9:0]         vertex_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [9:0]         corner_a,
  input  logic [9:0]         corner_b,
  input  logic [9:0]         corner_c,
  output logic               done,
  output logic [9:0]         read_index,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               zero_length
);

  logic          cmd_valid, pop;
  svn_pkg::cmd_t cmd;

  svn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .pop          (pop)
  );

  svn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .pop         (pop),
    .done        (done),
    .read_index  (read_index),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .zero_length (zero_length)
  );

endmodule

### src/svn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module svn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/svn_front.sv
// front end: takes commands, checks index ranges and corner repeats,
// and queues them for the back end; uses svn_pkg
module svn_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [9:0]         vertex_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [9:0]         corner_a,
  input  logic [9:0]         corner_b,
  input  logic [9:0]         corner_c,
  output logic               cmd_valid,
  output svn_pkg::cmd_t      cmd,
  input  logic               pop
);

  svn_pkg::cmd_t q [2];
  svn_pkg::cmd_t entry;
  logic          wp, rp;
  logic [1:0]    count;
  logic          push, do_push;
  logic          vi_ok, tri_ok;

  assign vi_ok  = 32'(vertex_index) < MAX_VERTICES;
  assign tri_ok = (32'(corner_a) < MAX_VERTICES) && (32'(corner_b) < MAX_VERTICES) &&
                  (32'(corner_c) < MAX_VERTICES);

  always_comb begin
    entry.idx   = vertex_index;
    entry.px    = pos_x;
    entry.py    = pos_y;
    entry.pz    = pos_z;
    entry.ca    = corner_a;
    entry.cb    = corner_b;
    entry.cc    = corner_c;
    entry.b_new = corner_b != corner_a;
    entry.c_new = (corner_c != corner_a) && (corner_c != corner_b);
    entry.op    = svn_pkg::OP_LOAD;
    push        = 1'b0;
    case (kind)
      svn_pkg::KIND_LOAD: begin
        push = vi_ok;
      end
      svn_pkg::KIND_TRI: begin
        entry.op = svn_pkg::OP_TRI;
        push     = tri_ok;
      end
      svn_pkg::KIND_READ: begin
        entry.op = vi_ok ? svn_pkg::OP_READ : svn_pkg::OP_READ_BAD;
        push     = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign busy      = count == 2'd2;
  assign do_push   = start && !busy && push;
  assign cmd_valid = count != 2'd0;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, do_push} - {1'b0, pop};
    end
  end

endmodule

### src/svn_norm.sv
// iterative normaliser: scales a 3-vector to unit length in Q1.15
// one shift, square, root bit or quotient bit per cycle; uses svn_pkg
module svn_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [svn_pkg::CW-1:0]  vx,
  input  logic signed [svn_pkg::CW-1:0]  vy,
  input  logic signed [svn_pkg::CW-1:0]  vz,
  output logic                           done,
  output logic                           zero,
  output logic signed [15:0]             nx,
  output logic signed [15:0]             ny,
  output logic signed [15:0]             nz
);

  localparam int CW = svn_pkg::CW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_SQ, S_ROOT, S_DLOAD, S_DIV, S_STORE, S_DONE
  } state_t;

  state_t             state;
  logic [CW-1:0]      mag [3];
  logic [2:0]         sgn;
  logic [61:0]        acc;
  logic [61:0]        res;
  logic [61:0]        bitv;
  logic [1:0]         cnt;
  logic [4:0]         step;
  logic [31:0]        rem;
  logic [16:0]        nlow;
  logic [16:0]        q;
  logic [32:0]        dd;
  logic signed [15:0] n [3];

  logic [CW-1:0] mx;
  logic [59:0]   sq;
  logic [61:0]   trial;
  logic [46:0]   numer;
  logic [32:0]   remsh;
  logic [15:0]   qs;

  function automatic logic [CW-1:0] abs_v(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  assign sq    = mag[cnt][29:0] * mag[cnt][29:0];
  assign trial = res + bitv;
  assign numer = {1'b0, mag[cnt][29:0], 16'b0} + 47'(res[31:0]);
  assign remsh = {rem, nlow[16]};
  assign qs    = (q > 17'd32767) ? 16'd32767 : q[15:0];

  assign nx = n[0];
  assign ny = n[1];
  assign nz = n[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      zero  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mag[0] <= abs_v(vx);
            mag[1] <= abs_v(vy);
            mag[2] <= abs_v(vz);
            sgn    <= {vz[CW-1], vy[CW-1], vx[CW-1]};
            if (vx == '0 && vy == '0 && vz == '0) begin
              zero  <= 1'b1;
              n[0]  <= '0;
              n[1]  <= '0;
              n[2]  <= '0;
              state <= S_DONE;
            end else begin
              zero  <= 1'b0;
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (mx[CW-1:30] != '0) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else if (!mx[29]) begin
            mag[0] <= mag[0] << 1;
            mag[1] <= mag[1] << 1;
            mag[2] <= mag[2] << 1;
          end else begin
            acc   <= '0;
            cnt   <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          acc <= acc + 62'(sq);
          if (cnt == 2'd2) begin
            res   <= '0;
            bitv  <= 62'(1) << 60;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        S_ROOT: begin
          if (acc >= trial) begin
            acc <= acc - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            cnt   <= 2'd0;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          // quotient stays below 2^17, so the top bits are already below the divisor
          rem   <= 32'(numer[46:17]);
          nlow  <= numer[16:0];
          q     <= '0;
          step  <= '0;
          dd    <= {res[31:0], 1'b0};
          state <= S_DIV;
        end
        S_DIV: begin
          if (remsh >= dd) begin
            rem <= 32'(remsh - dd);
            q   <= {q[15:0], 1'b1};
          end else begin
            rem <= remsh[31:0];
            q   <= {q[15:0], 1'b0};
          end
          nlow <= nlow << 1;
          step <= step + 5'd1;
          if (step == 5'd16) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          n[cnt] <= sgn[cnt] ? -$signed(qs) : $signed(qs);
          if (cnt == 2'd2) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 2'd1;
            state <= S_DLOAD;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/svn_back.sv
// back end: runs queued commands against the position and sum memories
// depends on svn_pkg, svn_ram and svn_norm
module svn_back #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  svn_pkg::cmd_t      cmd,
  output logic               pop,
  output logic               done,
  output logic [9:0]         read_index,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               zero_length
);

  localparam int CW = svn_pkg::CW;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int EW = (AW > 10) ? AW : 10;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_PA, B_PB, B_PC, B_PD, B_MUL, B_NSTART, B_NWAIT,
    B_SRD, B_SWR, B_RRD, B_RSTART, B_RWAIT
  } state_t;

  state_t              state;
  svn_pkg::cmd_t       c;
  logic [47:0]         pa, pb;
  logic signed [16:0]  d1 [3];
  logic signed [16:0]  d2 [3];
  logic signed [CW-1:0] cr [3];
  logic [2:0]          mstep;
  logic [1:0]          tgt;

  logic               p_we, s_we;
  logic [AW-1:0]      p_raddr, s_raddr, s_waddr, tgt_addr;
  logic [47:0]        p_rdata;
  logic [95:0]        s_rdata, s_wdata;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic               n_start, n_done, n_zero;
  logic signed [15:0] n_x, n_y, n_z;
  logic signed [CW-1:0] vx, vy, vz;

  function automatic logic [AW-1:0] to_addr(input logic [9:0] i);
    logic [EW-1:0] e;
    e = EW'(i);
    return e[AW-1:0];
  endfunction

  function automatic logic [31:0] sat_add(input logic signed [31:0] s,
                                          input logic signed [15:0] n);
    logic signed [32:0] t;
    t = 33'(s) + 33'(n);
    if (t[32] != t[31]) begin
      return t[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return t[31:0];
  endfunction

  assign pop = (state == B_IDLE) && cmd_valid;

  always_comb begin
    case (tgt)
      2'd0:    tgt_addr = to_addr(c.ca);
      2'd1:    tgt_addr = to_addr(c.cb);
      default: tgt_addr = to_addr(c.cc);
    endcase
    case (state)
      B_PA:    p_raddr = to_addr(c.ca);
      B_PB:    p_raddr = to_addr(c.cb);
      default: p_raddr = to_addr(c.cc);
    endcase
  end

  assign p_we    = state == B_LOAD;
  assign s_we    = (state == B_LOAD) || (state == B_SWR);
  assign s_waddr = (state == B_LOAD) ? to_addr(c.idx) : tgt_addr;
  assign s_raddr = (state == B_RRD) ? to_addr(c.idx) : tgt_addr;
  assign s_wdata = (state == B_LOAD) ? 96'd0 :
                   {sat_add(s_rdata[95:64], n_z), sat_add(s_rdata[63:32], n_y),
                    sat_add(s_rdata[31:0], n_x)};

  svn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_pos (
    .clk   (clk),
    .we    (p_we),
    .waddr (to_addr(c.idx)),
    .wdata ({c.pz, c.py, c.px}),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  svn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_sum (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // one multiplier walks the six cross product terms
  always_comb begin
    case (mstep)
      3'd0:    begin ma = d1[1]; mb = d2[2]; end
      3'd1:    begin ma = d1[2]; mb = d2[1]; end
      3'd2:    begin ma = d1[2]; mb = d2[0]; end
      3'd3:    begin ma = d1[0]; mb = d2[2]; end
      3'd4:    begin ma = d1[0]; mb = d2[1]; end
      default: begin ma = d1[1]; mb = d2[0]; end
    endcase
  end

  assign prod = ma * mb;

  assign n_start = (state == B_NSTART) || (state == B_RSTART);
  assign vx = (state == B_RSTART) ? CW'($signed(s_rdata[31:0]))  : cr[0];
  assign vy = (state == B_RSTART) ? CW'($signed(s_rdata[63:32])) : cr[1];
  assign vz = (state == B_RSTART) ? CW'($signed(s_rdata[95:64])) : cr[2];

  svn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (n_start),
    .vx    (vx),
    .vy    (vy),
    .vz    (vz),
    .done  (n_done),
    .zero  (n_zero),
    .nx    (n_x),
    .ny    (n_y),
    .nz    (n_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            c <= cmd;
            case (cmd.op)
              svn_pkg::OP_LOAD: state <= B_LOAD;
              svn_pkg::OP_TRI:  state <= B_PA;
              svn_pkg::OP_READ: state <= B_RRD;
              default: begin
                read_index  <= cmd.idx;
                normal_x    <= '0;
                normal_y    <= '0;
                normal_z    <= '0;
                zero_length <= 1'b1;
                done        <= 1'b1;
              end
            endcase
          end
        end
        B_LOAD: begin
          state <= B_IDLE;
        end
        B_PA: begin
          state <= B_PB;
        end
        B_PB: begin
          pa    <= p_rdata;
          state <= B_PC;
        end
        B_PC: begin
          pb    <= p_rdata;
          state <= B_PD;
        end
        B_PD: begin
          d1[0] <= 17'($signed(pb[15:0]))  - 17'($signed(pa[15:0]));
          d1[1] <= 17'($signed(pb[31:16])) - 17'($signed(pa[31:16]));
          d1[2] <= 17'($signed(pb[47:32])) - 17'($signed(pa[47:32]));
          d2[0] <= 17'($signed(p_rdata[15:0]))  - 17'($signed(pa[15:0]));
          d2[1] <= 17'($signed(p_rdata[31:16])) - 17'($signed(pa[31:16]));
          d2[2] <= 17'($signed(p_rdata[47:32])) - 17'($signed(pa[47:32]));
          mstep <= 3'd0;
          state <= B_MUL;
        end
        B_MUL: begin
          case (mstep)
            3'd0:    cr[0] <= CW'(prod);
            3'd1:    cr[0] <= cr[0] - CW'(prod);
            3'd2:    cr[1] <= CW'(prod);
            3'd3:    cr[1] <= cr[1] - CW'(prod);
            3'd4:    cr[2] <= CW'(prod);
            default: cr[2] <= cr[2] - CW'(prod);
          endcase
          mstep <= mstep + 3'd1;
          if (mstep == 3'd5) begin
            state <= B_NSTART;
          end
        end
        B_NSTART: begin
          state <= B_NWAIT;
        end
        B_NWAIT: begin
          if (n_done) begin
            // a degenerate face adds nothing
            if (n_zero) begin
              state <= B_IDLE;
            end else begin
              tgt   <= 2'd0;
              state <= B_SRD;
            end
          end
        end
        B_SRD: begin
          state <= B_SWR;
        end
        B_SWR: begin
          if (tgt == 2'd0 && c.b_new) begin
            tgt   <= 2'd1;
            state <= B_SRD;
          end else if (tgt != 2'd2 && c.c_new) begin
            tgt   <= 2'd2;
            state <= B_SRD;
          end else begin
            state <= B_IDLE;
          end
        end
        B_RRD: begin
          state <= B_RSTART;
        end
        B_RSTART: begin
          state <= B_RWAIT;
        end
        B_RWAIT: begin
          if (n_done) begin
            read_index  <= c.idx;
            normal_x    <= n_x;
            normal_y    <= n_y;
            normal_z    <= n_z;
            zero_length <= n_zero;
            done        <= 1'b1;
            state       <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### src/svn_check.sv
// port-level checks for the smooth vertex normal block
// bound to smooth_vertex_normals; no other dependencies
module svn_check (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic               zero_length
);

  // a zero-length sum reports zero components
  a_zero_comp: assert property (@(posedge clk) disable iff (rst)
    done && zero_length |-> normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
    else $error("zero_length result with non-zero components");

  // components saturate at +-32767, never the most negative code
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x != -16'sd32768 && normal_y != -16'sd32768 && normal_z != -16'sd32768)
    else $error("normal component out of range");

  a_reset: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy set after reset");

  // the queue only fills on a transfer
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

endmodule

bind smooth_vertex_normals svn_check u_check (.*);
